// ===== hdl/fdrs_pkg.sv =====
// Shared types and constants for the forward-decay reservoir sampler.
package fdrs_pkg;

    localparam int KEY_W = 40;
    localparam int VAL_W = 64;

    localparam logic [19:0] DECAY_RESET    = 20'd93600;
    localparam logic [10:0] CAPACITY_RESET = 11'd1024;
    localparam logic [15:0] PERIOD_RESET   = 16'd60;

    // Underflow bound of a log2 weight: 1074 in Q.16.
    localparam logic [27:0] UNDER_LIMIT = 28'(1074 * 65536);

    typedef enum logic [1:0] {
        CFG_DECAY    = 2'd0,
        CFG_CAPACITY = 2'd1,
        CFG_PERIOD   = 2'd2
    } cfg_index_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_CHECK,
        S_PREP,
        S_RSC_RD,
        S_RSC_WR,
        S_DISPATCH,
        S_LOG,
        S_KEY,
        S_SCAN,
        S_SCAN_TAIL,
        S_DECIDE,
        S_READ_RD,
        S_READ_OUT
    } state_t;

    localparam logic OP_OFFER = 1'b0;
    localparam logic OP_READ  = 1'b1;

    typedef struct packed {
        logic                     operation;
        logic signed [VAL_W-1:0]  sample_value;
        logic [31:0]              now_seconds;
        logic [23:0]              random_fraction;
        logic [9:0]               entry_index;
    } request_t;

    typedef struct packed {
        logic [10:0]              sample_count;
        logic                     accepted;
        logic                     entry_valid;
        logic signed [VAL_W-1:0]  entry_value;
        logic signed [KEY_W-1:0]  entry_log_weight;
    } result_t;

    typedef struct packed {
        logic                     valid;
        logic signed [KEY_W-1:0]  key;
        logic signed [VAL_W-1:0]  value;
        logic signed [KEY_W-1:0]  weight;
    } entry_t;

    // Saturate a 42-bit signed value to the signed 40-bit range.
    function automatic logic signed [KEY_W-1:0] sat40(input logic signed [41:0] v);
        logic signed [KEY_W-1:0] r;
        if (v > 42'sd549755813887) r = 40'sh7F_FFFF_FFFF;
        else if (v < -42'sd549755813888) r = 40'sh80_0000_0000;
        else r = v[KEY_W-1:0];
        return r;
    endfunction

endpackage

// ===== hdl/fdrs_log2.sv =====
// Iterative base-2 logarithm in Q.16, one squaring per cycle.
module fdrs_log2
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [23:0] r,
    output logic        done,
    output logic [20:0] result
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [3:0]  step_reg, step_next;
    logic [30:0] x_reg, x_next;
    logic [4:0]  msb_reg, msb_next;
    logic [15:0] frac_reg, frac_next;
    logic [23:0] r_eff;
    logic [4:0]  msb;
    logic [61:0] sq;
    logic [31:0] t;

    always_comb
    begin
        r_eff = (r == 24'd0) ? 24'd1 : r;
        msb   = 5'd0;
        for (int i = 0; i < 24; i++)
        begin
            if (r_eff[i]) msb = 5'(i);
        end
        sq = 62'(x_reg) * 62'(x_reg);
        t  = sq[61:30];
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        x_next    = x_reg;
        msb_next  = msb_reg;
        frac_next = frac_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = 4'd0;
            msb_next  = msb;
            frac_next = 16'd0;
            x_next    = 31'({7'd0, r_eff} << (5'd30 - msb));
        end
        else if (busy_reg)
        begin
            // Square, then renormalise and emit one fraction bit.
            frac_next = {frac_reg[14:0], t[31]};
            x_next    = t[31] ? t[31:1] : t[30:0];
            step_next = step_reg + 4'd1;
            if (step_reg == 4'd15)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 4'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        msb_reg  <= msb_next;
        frac_reg <= frac_next;
    end

    assign done   = done_reg;
    assign result = {msb_reg, frac_reg};

endmodule

// ===== hdl/forward_decay_reservoir_sampler.sv =====
// Top level of the forward-decay priority reservoir sampler.
//
//  channel   signals                          transfer
//  --------  -------------------------------  ------------------------------
//  command   start, busy, request             start high while busy is low
//  result    done, result                     done high for one cycle
//  config    cfg_write, cfg_index, cfg_data   cfg_write high, no wait
//
// After reset a clearing pass writes every slot empty while busy is high.
// An offer runs a 16-step log2 unit, then one scan of the first capacity slots
// through the single read port. An operation that falls due for a rescale
// first sweeps all slots, each slot read and, if valid, written back.
// Each result is held on result for the single cycle that done is high; the
// receiver cannot stall it, and a new command may be given in that cycle.
module forward_decay_reservoir_sampler
#(
    parameter int SLOTS         = 1024,
    parameter int FRACTION_BITS = 24
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  fdrs_pkg::request_t  request,
    output logic                done,
    output fdrs_pkg::result_t   result,
    input  logic                cfg_write,
    input  logic [1:0]          cfg_index,
    input  logic [19:0]         cfg_data
);

    localparam int AW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 2);

    // Configuration registers.
    logic [19:0] decay_rate_reg;
    logic [10:0] capacity_reg;
    logic [15:0] period_reg;

    // Control and payload state.
    fdrs_pkg::state_t   state_reg, state_next;
    logic [AW-1:0]      idx_reg, idx_next;
    fdrs_pkg::request_t in_reg, in_next;
    logic [51:0]        prod_reg, prod_next;
    logic               rescale_reg, rescale_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [CW-1:0]      offer_count_reg, offer_count_next;
    logic [31:0]        landmark_reg, landmark_next;
    logic [31:0]        next_rescale_reg, next_rescale_next;
    logic [39:0]        lw_reg, lw_next;
    logic signed [39:0] key_reg, key_next;
    logic               fill_ok_reg, fill_ok_next;
    logic               free_found_reg, free_found_next;
    logic [AW-1:0]      free_idx_reg, free_idx_next;
    logic               min_found_reg, min_found_next;
    logic [AW-1:0]      min_idx_reg, min_idx_next;
    logic signed [39:0] min_key_reg, min_key_next;
    logic               pv_reg, pv_next;
    logic [AW-1:0]      pidx_reg, pidx_next;
    fdrs_pkg::result_t  result_reg, result_next;
    logic               done_reg, done_next;

    // Slot memory.
    fdrs_pkg::entry_t   mem [SLOTS];
    fdrs_pkg::entry_t   rd_q;
    fdrs_pkg::entry_t   mem_wdata;
    logic [AW-1:0]      mem_raddr, mem_waddr;
    logic               mem_we;

    // Derived values.
    logic [CW-1:0]      cap;
    logic [31:0]        elapsed;
    logic [32:0]        deadline_sum;
    logic [12:0]        ent_ext;
    logic               ent_in_range;
    logic               log_start, log_done;
    logic [20:0]        log_val;
    logic               dec_big;
    logic signed [41:0] new_w, new_k;
    logic               survive;
    fdrs_pkg::entry_t   swept;
    logic [CW-1:0]      oc_inc;
    logic [CW-1:0]      sample_min;

    fdrs_log2 u_log2
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (log_start),
        .r      (in_reg.random_fraction),
        .done   (log_done),
        .result (log_val)
    );

    // Clamp capacity to 1..SLOTS.
    always_comb
    begin
        if (capacity_reg == 11'd0) cap = CW'(1);
        else if (32'(capacity_reg) > 32'(SLOTS)) cap = CW'(SLOTS);
        else cap = CW'(capacity_reg);
    end

    assign elapsed = (in_reg.now_seconds >= landmark_reg)
                   ? in_reg.now_seconds - landmark_reg : 32'd0;
    assign deadline_sum = 33'(in_reg.now_seconds) + 33'(period_reg);
    assign ent_ext      = 13'(in_reg.entry_index);
    assign ent_in_range = ent_ext < 13'(SLOTS);
    assign log_start    = (state_reg == fdrs_pkg::S_DISPATCH)
                       && (in_reg.operation == fdrs_pkg::OP_OFFER);
    assign oc_inc       = (offer_count_reg < cap + CW'(1))
                        ? offer_count_reg + CW'(1) : offer_count_reg;
    assign sample_min   = (offer_count_reg < cap) ? offer_count_reg : cap;

    // Rescale of one entry: subtract the decay, drop on underflow.
    always_comb
    begin
        dec_big = prod_reg > 52'(fdrs_pkg::UNDER_LIMIT);
        new_w   = 42'(rd_q.weight) - $signed({14'd0, prod_reg[27:0]});
        new_k   = 42'(rd_q.key) - $signed({14'd0, prod_reg[27:0]});
        survive = rd_q.valid && !dec_big
               && !(new_w < -$signed({14'd0, fdrs_pkg::UNDER_LIMIT}));
        swept        = rd_q;
        swept.valid  = survive;
        swept.weight = new_w[39:0];
        swept.key    = fdrs_pkg::sat40(new_k);
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fdrs_pkg::S_INIT:
                if (idx_reg == AW'(SLOTS - 1)) state_next = fdrs_pkg::S_IDLE;
            fdrs_pkg::S_IDLE:
                if (start) state_next = fdrs_pkg::S_CHECK;
            fdrs_pkg::S_CHECK:
                state_next = fdrs_pkg::S_PREP;
            fdrs_pkg::S_PREP:
                state_next = rescale_reg ? fdrs_pkg::S_RSC_RD : fdrs_pkg::S_DISPATCH;
            fdrs_pkg::S_RSC_RD:
                state_next = fdrs_pkg::S_RSC_WR;
            fdrs_pkg::S_RSC_WR:
                state_next = (idx_reg == AW'(SLOTS - 1))
                           ? fdrs_pkg::S_DISPATCH : fdrs_pkg::S_RSC_RD;
            fdrs_pkg::S_DISPATCH:
                state_next = (in_reg.operation == fdrs_pkg::OP_READ)
                           ? fdrs_pkg::S_READ_RD : fdrs_pkg::S_LOG;
            fdrs_pkg::S_LOG:
                if (log_done) state_next = fdrs_pkg::S_KEY;
            fdrs_pkg::S_KEY:
                state_next = fdrs_pkg::S_SCAN;
            fdrs_pkg::S_SCAN:
                if (CW'(idx_reg) == cap - CW'(1)) state_next = fdrs_pkg::S_SCAN_TAIL;
            fdrs_pkg::S_SCAN_TAIL:
                state_next = fdrs_pkg::S_DECIDE;
            fdrs_pkg::S_DECIDE:
                state_next = fdrs_pkg::S_IDLE;
            fdrs_pkg::S_READ_RD:
                state_next = fdrs_pkg::S_READ_OUT;
            fdrs_pkg::S_READ_OUT:
                state_next = fdrs_pkg::S_IDLE;
            default:
                state_next = fdrs_pkg::S_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb
    begin
        idx_next          = idx_reg;
        in_next           = in_reg;
        prod_next         = prod_reg;
        rescale_next      = rescale_reg;
        cnt_next          = cnt_reg;
        offer_count_next  = offer_count_reg;
        landmark_next     = landmark_reg;
        next_rescale_next = next_rescale_reg;
        lw_next           = lw_reg;
        key_next          = key_reg;
        fill_ok_next      = fill_ok_reg;
        free_found_next   = free_found_reg;
        free_idx_next     = free_idx_reg;
        min_found_next    = min_found_reg;
        min_idx_next      = min_idx_reg;
        min_key_next      = min_key_reg;
        pv_next           = (state_reg == fdrs_pkg::S_SCAN);
        pidx_next         = idx_reg;
        result_next       = result_reg;
        done_next         = 1'b0;
        mem_we            = 1'b0;
        mem_waddr         = idx_reg;
        mem_wdata         = '0;
        mem_raddr         = idx_reg;

        // Fold the entry read during the scan into the trackers.
        if (pv_reg)
        begin
            if (!rd_q.valid && !free_found_reg)
            begin
                free_found_next = 1'b1;
                free_idx_next   = pidx_reg;
            end
            if (rd_q.valid && (!min_found_reg || rd_q.key < min_key_reg))
            begin
                min_found_next = 1'b1;
                min_idx_next   = pidx_reg;
                min_key_next   = rd_q.key;
            end
        end

        unique case (state_reg)
            fdrs_pkg::S_INIT:
            begin
                mem_we   = 1'b1;
                idx_next = idx_reg + AW'(1);
            end
            fdrs_pkg::S_IDLE:
                if (start) in_next = request;
            fdrs_pkg::S_CHECK:
            begin
                prod_next    = 52'(decay_rate_reg) * 52'(elapsed);
                rescale_next = in_reg.now_seconds >= next_rescale_reg;
            end
            fdrs_pkg::S_PREP:
            begin
                if (rescale_reg)
                begin
                    landmark_next     = in_reg.now_seconds;
                    next_rescale_next = deadline_sum[32] ? 32'hFFFF_FFFF
                                                         : deadline_sum[31:0];
                    idx_next = '0;
                    cnt_next = '0;
                    lw_next  = 40'd0;
                end
                else
                begin
                    lw_next = (prod_reg > 52'h7F_FFFF_FFFF) ? 40'h7F_FFFF_FFFF
                                                            : prod_reg[39:0];
                end
            end
            fdrs_pkg::S_RSC_RD:
                ;
            fdrs_pkg::S_RSC_WR:
            begin
                mem_we    = rd_q.valid;
                mem_wdata = swept;
                cnt_next  = cnt_reg + CW'(survive);
                idx_next  = idx_reg + AW'(1);
                if (idx_reg == AW'(SLOTS - 1)) offer_count_next = cnt_reg + CW'(survive);
            end
            fdrs_pkg::S_DISPATCH:
            begin
                if (in_reg.operation == fdrs_pkg::OP_OFFER)
                begin
                    offer_count_next = oc_inc;
                    fill_ok_next     = oc_inc <= cap;
                end
                free_found_next = 1'b0;
                min_found_next  = 1'b0;
                idx_next        = '0;
            end
            fdrs_pkg::S_LOG:
                ;
            fdrs_pkg::S_KEY:
                key_next = fdrs_pkg::sat40($signed({2'd0, lw_reg})
                         + 42'sd1 * 42'(FRACTION_BITS * 65536)
                         - $signed({21'd0, log_val}));
            fdrs_pkg::S_SCAN:
                idx_next = idx_reg + AW'(1);
            fdrs_pkg::S_SCAN_TAIL:
                ;
            fdrs_pkg::S_DECIDE:
            begin
                mem_wdata = '{valid: 1'b1, key: key_reg, value: in_reg.sample_value,
                              weight: lw_reg};
                if (fill_ok_reg && free_found_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = free_idx_reg;
                end
                else if (min_found_reg && min_key_reg < key_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = min_idx_reg;
                end
                result_next              = '0;
                result_next.sample_count = 11'(sample_min);
                result_next.accepted     = mem_we;
                done_next                = 1'b1;
            end
            fdrs_pkg::S_READ_RD:
                mem_raddr = ent_ext[AW-1:0];
            fdrs_pkg::S_READ_OUT:
            begin
                result_next              = '0;
                result_next.sample_count = 11'(sample_min);
                if (ent_in_range && rd_q.valid)
                begin
                    result_next.entry_valid      = 1'b1;
                    result_next.entry_value      = rd_q.value;
                    result_next.entry_log_weight = rd_q.weight;
                end
                done_next = 1'b1;
            end
            default:
                ;
        endcase
    end

    // Memory: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        rd_q <= mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decay_rate_reg   <= fdrs_pkg::DECAY_RESET;
            capacity_reg     <= fdrs_pkg::CAPACITY_RESET;
            period_reg       <= fdrs_pkg::PERIOD_RESET;
            state_reg        <= fdrs_pkg::S_INIT;
            idx_reg          <= '0;
            offer_count_reg  <= '0;
            landmark_reg     <= 32'd0;
            next_rescale_reg <= 32'(fdrs_pkg::PERIOD_RESET);
            pv_reg           <= 1'b0;
            done_reg         <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (fdrs_pkg::cfg_index_t'(cfg_index))
                    fdrs_pkg::CFG_DECAY:    decay_rate_reg <= cfg_data;
                    fdrs_pkg::CFG_CAPACITY: capacity_reg   <= cfg_data[10:0];
                    fdrs_pkg::CFG_PERIOD:   period_reg     <= cfg_data[15:0];
                    default:                ;
                endcase
            end
            state_reg        <= state_next;
            idx_reg          <= idx_next;
            offer_count_reg  <= offer_count_next;
            landmark_reg     <= landmark_next;
            next_rescale_reg <= next_rescale_next;
            pv_reg           <= pv_next;
            done_reg         <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_reg         <= in_next;
        prod_reg       <= prod_next;
        rescale_reg    <= rescale_next;
        cnt_reg        <= cnt_next;
        lw_reg         <= lw_next;
        key_reg        <= key_next;
        fill_ok_reg    <= fill_ok_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        min_found_reg  <= min_found_next;
        min_idx_reg    <= min_idx_next;
        min_key_reg    <= min_key_next;
        pidx_reg       <= pidx_next;
        result_reg     <= result_next;
    end

    assign busy   = (state_reg != fdrs_pkg::S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

`ifndef SYNTHESIS
    a_done_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(state_reg) == fdrs_pkg::S_DECIDE
                   || $past(state_reg) == fdrs_pkg::S_READ_OUT))
        else $error("result strobe without a finishing step");
    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fdrs_pkg::S_SCAN) |-> (CW'(idx_reg) < cap))
        else $error("scan beyond capacity");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(offer_count_reg) <= 32'(SLOTS + 1))
        else $error("offer count out of range");
    a_log_in_log_state: assert property (@(posedge clk) disable iff (!rst_n)
        log_done |-> (state_reg == fdrs_pkg::S_LOG))
        else $error("log2 result outside its wait state");
`endif

endmodule
